FILE: src/modbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbt_pkg
// Shared constants, request codes and state type of the bit table packer.
// ----------------------------------------------------------------------------
package modbt_pkg;

  localparam int TABLE_BITS    = 2048;
  localparam int MAX_READ_BITS = 512;

  localparam int TYPE_W  = 2;
  localparam int ADDR_W  = 11;
  localparam int COUNT_W = 10;
  localparam int DATA_W  = 8;
  localparam int IDX_W   = 6;

  localparam int ROWS  = TABLE_BITS / DATA_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int OFF_W = $clog2(DATA_W);
  localparam int SUM_W = ADDR_W + 1;

  localparam logic [DATA_W-1:0] COIL_RESET  = '0;
  localparam logic [DATA_W-1:0] INPUT_RESET = '1;
  localparam logic [DATA_W-1:0] BIT_ONE     = DATA_W'(8'h01);

  typedef enum logic [TYPE_W-1:0] {
    REQ_WR_COIL  = 2'd0,
    REQ_WR_INPUT = 2'd1,
    REQ_RD_COIL  = 2'd2,
    REQ_RD_INPUT = 2'd3
  } req_type_t;

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_WR_MOD  = 6'b000100,
    ST_RD_LOAD = 6'b001000,
    ST_RD_EMIT = 6'b010000,
    ST_RESP    = 6'b100000
  } state_t;

endpackage

FILE: src/modbt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbt_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module modbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: src/modbus_bit_table_packer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_bit_table_packer_unit
// Coil and discrete-input bit tables with packed, byte-wise reads.
//
// Requests enter on the in_ channel (valid/stall), one at a time. A write
// sets one bit of the coil or discrete-input table and returns one
// acknowledge beat; a read returns ceil(count/8) beats of packed bits,
// lowest address in bit 0, the final beat marked out_last and zero-padded.
// A bad address range or count returns one beat with out_error set.
// Both tables sit in byte-wide RAMs of 256 rows; a write is a
// read-modify-write of one row: read on accept, written back in
// ST_WR_MOD, acknowledged from ST_RESP. A read fetches two rows up front,
// then one row per output beat, one beat per cycle while out_stall does
// not hold the output register. The next request, even after a full
// 64-byte read, is taken once the last beat sits in the output register.
// After reset a clearing pass over all 256 rows writes zeros to the coils
// and ones to the discrete inputs; in_stall stays high meanwhile.
// When out_stall is high the output register holds its beat, and the
// block waits to load its next beat until it is taken.
// ----------------------------------------------------------------------------
module modbus_bit_table_packer_unit
  import modbt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TYPE_W-1:0]  in_req_type,
  input  logic [ADDR_W-1:0]  in_bit_addr,
  input  logic [COUNT_W-1:0] in_bit_count,
  input  logic               in_set_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  out_data_byte,
  output logic [IDX_W-1:0]   out_byte_index,
  output logic               out_last,
  output logic               out_error
);

  state_t               state_r, state_nxt;
  logic [ROW_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic [COUNT_W-1:0]   left_r, left_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [DATA_W-1:0]    prev_r, prev_nxt;
  logic                 sel_r, sel_nxt;
  logic                 set_r, set_nxt;
  logic                 err_r, err_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    out_data_r, out_data_nxt;
  logic [IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_err_r, out_err_nxt;

  logic                 accept, out_free, out_load;
  logic                 is_read, bad_req, ram_issue, ram_we, cur_sel;
  logic [SUM_W-1:0]     range_end;
  logic [ROW_W-1:0]     ram_addr;
  logic [DATA_W-1:0]    coil_wdata, input_wdata, coil_rdata, input_rdata;
  logic [DATA_W-1:0]    rdata, mod_byte, mask, packed_byte;
  logic [2*DATA_W-1:0]  window;
  logic                 emit_last;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign is_read   = in_req_type[1];
  assign range_end = {1'b0, in_bit_addr} + SUM_W'(in_bit_count);

  always_comb begin
    if (is_read) begin
      bad_req = (in_bit_count == '0) ||
                (in_bit_count > COUNT_W'(MAX_READ_BITS)) ||
                (range_end > SUM_W'(TABLE_BITS));
    end else begin
      bad_req = ({1'b0, in_bit_addr} >= SUM_W'(TABLE_BITS));
    end
  end

  assign rdata  = sel_r ? input_rdata : coil_rdata;
  assign window = {rdata, prev_r} >> off_r;
  assign mask   = (left_r >= COUNT_W'(DATA_W)) ? '1 : ~('1 << left_r[OFF_W-1:0]);
  assign packed_byte = window[DATA_W-1:0] & mask;
  assign emit_last   = (left_r <= COUNT_W'(DATA_W));

  always_comb begin
    mod_byte = rdata;
    mod_byte[off_r] = set_r;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    row_nxt      = row_r;
    off_nxt      = off_r;
    left_nxt     = left_r;
    idx_nxt      = idx_r;
    prev_nxt     = prev_r;
    sel_nxt      = sel_r;
    set_nxt      = set_r;
    err_nxt      = err_r;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    out_idx_nxt  = out_idx_r;
    out_last_nxt = out_last_r;
    out_err_nxt  = out_err_r;
    ram_issue    = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = row_r;
    cur_sel      = sel_r;
    coil_wdata   = mod_byte;
    input_wdata  = mod_byte;

    case (state_r)
      ST_CLEAR: begin
        ram_addr    = clr_cnt_r;
        coil_wdata  = COIL_RESET;
        input_wdata = INPUT_RESET;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ROW_W'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cur_sel  = in_req_type[0];
        ram_addr = in_bit_addr[OFF_W +: ROW_W];
        if (accept) begin
          sel_nxt  = in_req_type[0];
          set_nxt  = in_set_value;
          off_nxt  = in_bit_addr[OFF_W-1:0];
          left_nxt = in_bit_count;
          idx_nxt  = '0;
          err_nxt  = bad_req;
          row_nxt  = in_bit_addr[OFF_W +: ROW_W] + ROW_W'(is_read);
          if (bad_req) begin
            state_nxt = ST_RESP;
          end else begin
            ram_issue = 1'b1;
            state_nxt = is_read ? ST_RD_LOAD : ST_WR_MOD;
          end
        end
      end
      ST_WR_MOD: begin
        ram_issue = 1'b1;
        ram_we    = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RD_LOAD: begin
        prev_nxt  = rdata;
        ram_issue = 1'b1;
        row_nxt   = row_r + 1'b1;
        state_nxt = ST_RD_EMIT;
      end
      ST_RD_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = packed_byte;
          out_idx_nxt  = idx_r;
          out_last_nxt = emit_last;
          out_err_nxt  = 1'b0;
          prev_nxt     = rdata;
          idx_nxt      = idx_r + 1'b1;
          left_nxt     = left_r - COUNT_W'(DATA_W);
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_issue = 1'b1;
            row_nxt   = row_r + 1'b1;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = '0;
          out_idx_nxt  = '0;
          out_last_nxt = 1'b1;
          out_err_nxt  = err_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    off_r      <= off_nxt;
    left_r     <= left_nxt;
    idx_r      <= idx_nxt;
    prev_r     <= prev_nxt;
    sel_r      <= sel_nxt;
    set_r      <= set_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  modbt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ROWS)
  ) u_coil_ram (
    .clk   (clk),
    .en    ((state_r == ST_CLEAR) || (ram_issue && !cur_sel)),
    .we    ((state_r == ST_CLEAR) || ram_we),
    .addr  (ram_addr),
    .wdata (coil_wdata),
    .rdata (coil_rdata)
  );

  modbt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ROWS)
  ) u_input_ram (
    .clk   (clk),
    .en    ((state_r == ST_CLEAR) || (ram_issue && cur_sel)),
    .we    ((state_r == ST_CLEAR) || ram_we),
    .addr  (ram_addr),
    .wdata (input_wdata),
    .rdata (input_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_data_byte  = out_data_r;
  assign out_byte_index = out_idx_r;
  assign out_last       = out_last_r;
  assign out_error      = out_err_r;

  a_err_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r && out_data_r == '0 && out_idx_r == '0)
    else $error("error beat is not a single zero beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || !out_stall)
    else $error("output register overwritten while stalled");

  a_emit_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD_EMIT |-> left_r != '0)
    else $error("read emit with no bits left");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR_MOD |-> $past(state_r) == ST_IDLE && $past(accept))
    else $error("row write without a fresh row read");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> in_stall && !out_valid_r)
    else $error("activity during clearing pass");

endmodule

FILE: verif/modbt_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbt_reply_checker
// Watches both channels of the bit table packer and checks every result beat.
//
// Each accepted request is run against a private copy of the coil and
// discrete-input tables. Writes update that copy and expect one acknowledge.
// Reads expect packed bytes, lowest address in bit 0, with zero padding.
// Bad ranges or counts expect a single error beat. Accepted result beats are
// compared field by field against the oldest expected beat. The mismatch
// count and the number of beats still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module modbt_reply_checker
  import modbt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [TYPE_W-1:0]  in_req_type,
  input  logic [ADDR_W-1:0]  in_bit_addr,
  input  logic [COUNT_W-1:0] in_bit_count,
  input  logic               in_set_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [DATA_W-1:0]  out_data_byte,
  input  logic [IDX_W-1:0]   out_byte_index,
  input  logic               out_last,
  input  logic               out_error,
  output int                 mismatches,
  output int                 pending
);

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;
    logic              error;
  } reply_t;

  reply_t reply_q[$];
  bit     coil_tbl[TABLE_BITS];
  bit     input_tbl[TABLE_BITS];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  task automatic serve_request(input req_type_t kind, input int addr, input int count,
                               input bit value);
    int                nbytes;
    int                pos;
    logic [DATA_W-1:0] packed_bits;
    if (kind == REQ_WR_COIL || kind == REQ_WR_INPUT) begin
      if (addr >= TABLE_BITS) begin
        reply_q.push_back(reply_t'{DATA_W'(0), IDX_W'(0), 1'b1, 1'b1});
        return;
      end
      if (kind == REQ_WR_COIL) begin
        coil_tbl[addr] = value;
      end else begin
        input_tbl[addr] = value;
      end
      reply_q.push_back(reply_t'{DATA_W'(0), IDX_W'(0), 1'b1, 1'b0});
      return;
    end
    if (count == 0 || count > MAX_READ_BITS || addr + count > TABLE_BITS) begin
      reply_q.push_back(reply_t'{DATA_W'(0), IDX_W'(0), 1'b1, 1'b1});
      return;
    end
    nbytes = (count + DATA_W - 1) / DATA_W;
    for (int b = 0; b < nbytes; b++) begin
      packed_bits = '0;
      for (int i = 0; i < DATA_W; i++) begin
        pos = addr + b * DATA_W + i;
        if (b * DATA_W + i < count) begin
          packed_bits[i] = (kind == REQ_RD_COIL) ? coil_tbl[pos] : input_tbl[pos];
        end
      end
      reply_q.push_back(reply_t'{packed_bits, IDX_W'(b), b == nbytes - 1, 1'b0});
    end
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      reply_q.delete();
      foreach (coil_tbl[i]) begin
        coil_tbl[i]  = 1'b0;
        input_tbl[i] = 1'b1;
      end
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          report($sformatf("beat with nothing expected, data 0x%0h index %0d",
                           out_data_byte, out_byte_index));
        end else begin
          want = reply_q.pop_front();
          check_field("data_byte", out_data_byte, want.data_byte);
          check_field("byte_index", out_byte_index, want.byte_index);
          check_field("last", out_last, want.last);
          check_field("error", out_error, want.error);
        end
      end
      if (in_valid && !in_stall) begin
        serve_request(req_type_t'(in_req_type), in_bit_addr, in_bit_count, in_set_value);
      end
    end
    pending = reply_q.size();
  end

endmodule

FILE: verif/tb_modbus_bit_table_packer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_bit_table_packer_unit
// Stimulus and verdict for the coil and discrete-input bit table packer.
//
// A short directed run hits the table ends, every request kind, padding,
// the largest read and each error case. A random run follows: writes and
// reads clustered on a few address windows so reads see written bits, mostly
// short reads, a few long ones, and some bad counts and ranges. Requests go
// out in bursts with random gaps; the result side stalls in random phases.
// The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_modbus_bit_table_packer_unit;
  import modbt_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 330;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} flow_t;

  logic               clk;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [TYPE_W-1:0]  in_req_type  = '0;
  logic [ADDR_W-1:0]  in_bit_addr  = '0;
  logic [COUNT_W-1:0] in_bit_count = '0;
  logic               in_set_value = 1'b0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [DATA_W-1:0]  out_data_byte;
  logic [IDX_W-1:0]   out_byte_index;
  logic               out_last;
  logic               out_error;

  int    mismatches;
  int    pending;
  int    cycles     = 0;
  int    burst_left = 0;
  flow_t flow       = FLOW_FREE;

  modbus_bit_table_packer_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_bit_addr    (in_bit_addr),
    .in_bit_count   (in_bit_count),
    .in_set_value   (in_set_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .out_error      (out_error)
  );

  modbt_reply_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_bit_addr    (in_bit_addr),
    .in_bit_count   (in_bit_count),
    .in_set_value   (in_set_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .out_error      (out_error),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 47) == 0) begin
        flow = flow_t'($urandom_range(FLOW_FREE, FLOW_HEAVY));
      end
      case (flow)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:    out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // hold the beat until taken, then idle between bursts
  task automatic send_req(input req_type_t kind, input int addr, input int count,
                          input bit value);
    int gap;
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_bit_addr  <= ADDR_W'(addr);
    in_bit_count <= COUNT_W'(count);
    in_set_value <= value;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int window_addr();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 63);
      1:       return $urandom_range(TABLE_BITS - 64, TABLE_BITS - 1);
      2:       return $urandom_range(1000, 1063);
      default: return $urandom_range(0, TABLE_BITS - 1);
    endcase
  endfunction

  initial begin
    int        roll;
    int        addr;
    int        count;
    req_type_t rd_kind;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_req(REQ_WR_COIL, 0, 0, 1'b1);
    send_req(REQ_WR_COIL, TABLE_BITS - 1, 1023, 1'b1);
    send_req(REQ_WR_INPUT, 0, 0, 1'b0);
    send_req(REQ_WR_INPUT, TABLE_BITS - 1, 1023, 1'b0);
    send_req(REQ_WR_COIL, 5, 3, 1'b1);
    send_req(REQ_RD_COIL, 0, 1, 1'b0);
    send_req(REQ_RD_COIL, TABLE_BITS - 8, 8, 1'b1);
    send_req(REQ_RD_INPUT, 0, 9, 1'b0);
    send_req(REQ_RD_COIL, 0, MAX_READ_BITS, 1'b1);
    send_req(REQ_RD_INPUT, TABLE_BITS - MAX_READ_BITS, MAX_READ_BITS, 1'b0);
    send_req(REQ_RD_COIL, 0, 0, 1'b0);
    send_req(REQ_RD_INPUT, 0, MAX_READ_BITS + 1, 1'b1);
    send_req(REQ_RD_COIL, 1, 1023, 1'b1);
    send_req(REQ_RD_COIL, TABLE_BITS - 1, 2, 1'b0);
    send_req(REQ_RD_INPUT, TABLE_BITS - 1, 1, 1'b1);
    send_req(REQ_WR_COIL, 0, 1023, 1'b0);
    send_req(REQ_RD_COIL, 0, 16, 1'b0);
    send_req(REQ_WR_INPUT, 1234, 0, 1'b0);
    send_req(REQ_RD_INPUT, 1230, 17, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll    = $urandom_range(0, 99);
      addr    = window_addr();
      rd_kind = $urandom_range(0, 1) ? REQ_RD_INPUT : REQ_RD_COIL;
      if (roll < 40) begin
        send_req($urandom_range(0, 1) ? REQ_WR_INPUT : REQ_WR_COIL, addr,
                 $urandom_range(0, 1023), $urandom_range(0, 1));
      end else if (roll < 85) begin
        count = ($urandom_range(0, 19) == 0) ? $urandom_range(1, MAX_READ_BITS)
                                             : $urandom_range(1, 40);
        if (addr + count > TABLE_BITS) begin
          addr = TABLE_BITS - count;
        end
        send_req(rd_kind, addr, count, $urandom_range(0, 1));
      end else begin
        case ($urandom_range(0, 2))
          0: count = 0;
          1: count = $urandom_range(MAX_READ_BITS + 1, 1023);
          default: begin
            count = $urandom_range(2, MAX_READ_BITS);
            addr  = $urandom_range(TABLE_BITS + 1 - count, TABLE_BITS - 1);
          end
        endcase
        send_req(rd_kind, addr, count, $urandom_range(0, 1));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/modbt_pkg.sv
src/modbt_ram.sv
src/modbus_bit_table_packer_unit.sv
verif/modbt_reply_checker.sv
verif/tb_modbus_bit_table_packer_unit.sv
